@@ rtl/knms_pkg.sv @@
package knms_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int COORD_BITS  = 10;
  localparam int SCORE_BITS  = 16;
  localparam int QIDX_BITS   = 10;
  localparam int RAD_BITS    = 4;
  localparam int OP_BITS     = 2;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam int IDX_BITS  = $clog2(MAX_POINTS);
  localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
  localparam int CMP_BITS  = CNT_BITS + QIDX_BITS;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;
  localparam int R2_BITS   = 2 * RAD_BITS;
  localparam int MEM_BITS  = 2 * COORD_BITS + SCORE_BITS;

  // op codes
  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN = 1'd1;

  localparam logic [RAD_BITS-1:0] RADIUS_RESET = 4'd5;

  // queried point, held for the whole scan
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [SCORE_BITS-1:0] own;
  } knms_center_t;

  // compare pipeline status back to the sequencer
  typedef struct packed {
    logic busy;
    logic hit;
  } knms_cmp_stat_t;

endpackage

@@ rtl/knms_cmp.sv @@
module knms_cmp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              nb_valid,
  input  logic [knms_pkg::MEM_BITS-1:0]     nb_data,
  input  knms_pkg::knms_center_t            center,
  input  logic [knms_pkg::R2_BITS-1:0]      r2,
  input  logic [knms_pkg::SCORE_BITS-1:0]   margin,
  output knms_pkg::knms_cmp_stat_t          stat
);

  logic [knms_pkg::COORD_BITS-1:0] nx, ny, dx, dy;
  logic [knms_pkg::SCORE_BITS-1:0] ns;
  logic [knms_pkg::SCORE_BITS:0]   ns_plus;
  logic [knms_pkg::DIST_BITS-1:0]  dsq;

  logic                            v1_r, v2_r;
  logic                            same_r, beats_r, hit_r;
  logic [knms_pkg::SQ_BITS-1:0]    sqx_r, sqy_r;

  assign nx = nb_data[knms_pkg::MEM_BITS-1 -: knms_pkg::COORD_BITS];
  assign ny = nb_data[knms_pkg::SCORE_BITS +: knms_pkg::COORD_BITS];
  assign ns = nb_data[knms_pkg::SCORE_BITS-1:0];

  assign dx = (nx > center.cx) ? (nx - center.cx) : (center.cx - nx);
  assign dy = (ny > center.cy) ? (ny - center.cy) : (center.cy - ny);
  assign ns_plus = {1'b0, ns} + {1'b0, margin};

  // stage 1: squares and score test
  always_ff @(posedge clk) begin
    sqx_r   <= knms_pkg::SQ_BITS'(dx) * knms_pkg::SQ_BITS'(dx);
    sqy_r   <= knms_pkg::SQ_BITS'(dy) * knms_pkg::SQ_BITS'(dy);
    same_r  <= (nx == center.cx) && (ny == center.cy);
    beats_r <= ns_plus > {1'b0, center.own};
  end

  assign dsq = {1'b0, sqx_r} + {1'b0, sqy_r};

  // stage 2: distance test
  always_ff @(posedge clk) begin
    hit_r <= v1_r && !same_r && beats_r &&
             (dsq < knms_pkg::DIST_BITS'(r2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= nb_valid;
      v2_r <= v1_r;
    end
  end

  assign stat.busy = v1_r || v2_r;
  assign stat.hit  = v2_r && hit_r;

endmodule

@@ rtl/keypoint_radius_nms.sv @@
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_valid / in_stall  | op, pos_x, pos_y, score, query_index
// out_    | out | out_valid / out_stall| valid_res, kept, x, y, point_count, overflow
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Load, clear and ignored ops are handled in idle; a new item follows at once.
// A query fetches the center, reads the store once per stored point, drains
// the two-stage compare, hands off to the output register and returns to idle.
// An out-of-range query goes straight to the done state. The next item waits
// until the query's result sits in the output register.
// Reset is synchronous (rst_n low): count, overflow flag, radius 5, margin 0;
// the point store itself is not cleared, only entries below the count are read.
// out_stall only holds the output register; loads still go on behind it.
module keypoint_radius_nms (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [knms_pkg::OP_BITS-1:0]          in_op,
  input  logic [knms_pkg::COORD_BITS-1:0]       in_pos_x,
  input  logic [knms_pkg::COORD_BITS-1:0]       in_pos_y,
  input  logic [knms_pkg::SCORE_BITS-1:0]       in_score,
  input  logic [knms_pkg::QIDX_BITS-1:0]        in_query_index,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_valid_res,
  output logic                                  out_kept,
  output logic [knms_pkg::COORD_BITS-1:0]       out_x,
  output logic [knms_pkg::COORD_BITS-1:0]       out_y,
  output logic [knms_pkg::CNT_BITS-1:0]         out_point_count,
  output logic                                  out_overflow,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [knms_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [knms_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CENTER = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] state_r, state_nxt;

  // config
  logic [knms_pkg::RAD_BITS-1:0]   radius_r;
  logic [knms_pkg::SCORE_BITS-1:0] margin_r;
  logic [knms_pkg::R2_BITS-1:0]    r2;

  // store bookkeeping
  logic [knms_pkg::CNT_BITS-1:0]   count_r, count_nxt;
  logic                            drop_r, drop_nxt;

  // point store: {x, y, score}, one write and one read port
  logic [knms_pkg::MEM_BITS-1:0]   mem [knms_pkg::MAX_POINTS];
  logic [knms_pkg::MEM_BITS-1:0]   rd_data_r;
  logic [knms_pkg::IDX_BITS-1:0]   rd_addr;
  logic                            wr_en;

  // scan control
  logic [knms_pkg::CNT_BITS-1:0]   iss_r, iss_nxt;
  logic                            nb_valid_r, nb_valid_nxt;
  logic                            supp_r, supp_nxt;
  logic                            qok_r, qok_nxt;
  knms_pkg::knms_center_t          center_r;
  logic                            center_ld;
  knms_pkg::knms_cmp_stat_t        cmp_stat;

  logic                            in_acc;
  logic                            q_in_range;
  logic                            out_free;
  logic                            out_ld;
  logic                            out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign r2        = knms_pkg::R2_BITS'(radius_r) * knms_pkg::R2_BITS'(radius_r);

  assign q_in_range = knms_pkg::CMP_BITS'(in_query_index) < knms_pkg::CMP_BITS'(count_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= knms_pkg::RADIUS_RESET;
      margin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        knms_pkg::REG_RADIUS: radius_r <= cfg_data[knms_pkg::RAD_BITS-1:0];
        knms_pkg::REG_MARGIN: margin_r <= cfg_data[knms_pkg::SCORE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    iss_nxt      = iss_r;
    nb_valid_nxt = 1'b0;
    supp_nxt     = supp_r || cmp_stat.hit;
    qok_nxt      = qok_r;
    rd_addr      = iss_r[knms_pkg::IDX_BITS-1:0];
    wr_en        = 1'b0;
    center_ld    = 1'b0;
    out_ld       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = knms_pkg::IDX_BITS'(in_query_index);
        if (in_acc) begin
          case (in_op)
            knms_pkg::OP_LOAD: begin
              if (count_r < knms_pkg::CNT_BITS'(knms_pkg::MAX_POINTS)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            knms_pkg::OP_CLEAR: begin
              count_nxt = '0;
              drop_nxt  = 1'b0;
            end
            knms_pkg::OP_QUERY: begin
              qok_nxt   = q_in_range;
              supp_nxt  = 1'b0;
              state_nxt = q_in_range ? ST_CENTER : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_CENTER: begin
        // queried point is on the read port; start the scan at entry 0
        center_ld    = 1'b1;
        rd_addr      = '0;
        iss_nxt      = knms_pkg::CNT_BITS'(1);
        nb_valid_nxt = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (iss_r < count_r) begin
          iss_nxt      = iss_r + 1'b1;
          nb_valid_nxt = 1'b1;
        end else if (!nb_valid_r && !cmp_stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      drop_r     <= 1'b0;
      iss_r      <= '0;
      nb_valid_r <= 1'b0;
      supp_r     <= 1'b0;
      qok_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      drop_r     <= drop_nxt;
      iss_r      <= iss_nxt;
      nb_valid_r <= nb_valid_nxt;
      supp_r     <= supp_nxt;
      qok_r      <= qok_nxt;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[knms_pkg::IDX_BITS-1:0]] <= {in_pos_x, in_pos_y, in_score};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (center_ld) begin
      center_r <= knms_pkg::knms_center_t'(rd_data_r);
    end
  end

  knms_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .nb_valid (nb_valid_r),
    .nb_data  (rd_data_r),
    .center   (center_r),
    .r2       (r2),
    .margin   (margin_r),
    .stat     (cmp_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_valid_res   <= qok_r;
      out_kept        <= qok_r && !supp_r;
      out_x           <= qok_r ? center_r.cx : '0;
      out_y           <= qok_r ? center_r.cy : '0;
      out_point_count <= count_r;
      out_overflow    <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= knms_pkg::CNT_BITS'(knms_pkg::MAX_POINTS))
    else $error("point count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= count_r))
    else $error("scan ran past stored count");

  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(count_r))
    else $error("count changed during a scan");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside query completion");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_IDLE))
    else $error("store written during a query");

endmodule

@@ verif/keypoint_radius_nms_tb.sv @@
`timescale 1ns / 1ps

module keypoint_radius_nms_tb;
  import knms_pkg::*;

  // op 3 has no meaning; the block must swallow it silently
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 16;      // trailing loads/clears still in flight
  localparam int TAIL_CYCLES   = 32;
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BATCH_ITEMS   = 66;
  localparam int CLUSTER_CAP   = 40;      // keeps most scans short
  localparam int N_SETTINGS    = 8;
  localparam int PRESSURE_SET  = 6;
  localparam int MAX_SHOWN     = 50;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SCORE_BITS-1:0] score;
    logic [QIDX_BITS-1:0]  qidx;
  } nms_item_t;

  typedef struct packed {
    logic                  valid_res;
    logic                  kept;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CNT_BITS-1:0]   count;
    logic                  overflow;
  } nms_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_BITS-1:0]       in_op = OP_LOAD;
  logic [COORD_BITS-1:0]    in_pos_x = '0;
  logic [COORD_BITS-1:0]    in_pos_y = '0;
  logic [SCORE_BITS-1:0]    in_score = '0;
  logic [QIDX_BITS-1:0]     in_query_index = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_valid_res;
  logic                     out_kept;
  logic [COORD_BITS-1:0]    out_x;
  logic [COORD_BITS-1:0]    out_y;
  logic [CNT_BITS-1:0]      out_point_count;
  logic                     out_overflow;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_RADIUS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  keypoint_radius_nms dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_score        (in_score),
    .in_query_index  (in_query_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_kept        (out_kept),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_point_count (out_point_count),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  nms_item_t    item_q[$];      // items waiting to be offered
  nms_verdict_t verdict_q[$];   // expected query verdicts, oldest first
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_req = 0;   // bumped by stimulus to ask for a long hold-off
  int           gen_count = 0;  // store occupancy as seen by the generator
  int           mismatches = 0;
  int           results_seen = 0;
  int unsigned  cycle_count = 0;

  // Predictor's own copy of the store and registers
  logic [COORD_BITS-1:0] pt_col [MAX_POINTS];
  logic [COORD_BITS-1:0] pt_row [MAX_POINTS];
  logic [SCORE_BITS-1:0] pt_score [MAX_POINTS];
  int                    pt_count = 0;
  logic                  pt_dropped = 1'b0;
  logic [RAD_BITS-1:0]   radius_cfg = RADIUS_RESET;
  logic [SCORE_BITS-1:0] margin_cfg = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Scan the whole store; a neighbor at the same position never counts.
  function automatic bit point_survives(int idx);
    int cx, cy, own, nx, ny, dx, dy, r2, j;
    cx  = pt_col[idx];
    cy  = pt_row[idx];
    own = pt_score[idx];
    r2  = int'(radius_cfg) * int'(radius_cfg);
    for (j = 0; j < pt_count; j++) begin
      nx = pt_col[j];
      ny = pt_row[j];
      if (nx == cx && ny == cy) continue;
      dx = (nx > cx) ? nx - cx : cx - nx;
      dy = (ny > cy) ? ny - cy : cy - ny;
      // margin is added on the neighbor side so nothing underflows
      if (dx * dx + dy * dy < r2 && int'(pt_score[j]) + int'(margin_cfg) > own)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_verdict(nms_item_t it);
    nms_verdict_t v;
    int q;
    case (it.op)
      OP_LOAD: begin
        if (pt_count < MAX_POINTS) begin
          pt_col[pt_count]   = it.x;
          pt_row[pt_count]   = it.y;
          pt_score[pt_count] = it.score;
          pt_count++;
        end else begin
          pt_dropped = 1'b1;   // full store: point lost, flag sticks
        end
      end
      OP_CLEAR: begin
        pt_count   = 0;
        pt_dropped = 1'b0;
      end
      OP_QUERY: begin
        q = it.qidx;
        v = '0;
        if (q < pt_count) begin
          v.valid_res = 1'b1;
          v.kept      = point_survives(q);
          v.x         = pt_col[q];
          v.y         = pt_row[q];
        end
        v.count    = CNT_BITS'(pt_count);
        v.overflow = pt_dropped;
        verdict_q = {verdict_q, v};
      end
      default: ;  // unused op: no state change, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nms_item_t nxt, seen;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        seen.op    = in_op;
        seen.x     = in_pos_x;
        seen.y     = in_pos_y;
        seen.score = in_score;
        seen.qidx  = in_query_index;
        predict_verdict(seen);
      end
      // payload only moves once the current item is gone
      if (!in_valid || !in_stall) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = item_q.pop_front();
          in_valid       <= 1'b1;
          in_op          <= nxt.op;
          in_pos_x       <= nxt.x;
          in_pos_y       <= nxt.y;
          in_score       <= nxt.score;
          in_query_index <= nxt.qidx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results, drives out_stall (random or long hold-off)
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, int got, int want);
    if (mismatches < MAX_SHOWN)
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, results_seen, what,
               got, want);
    mismatches++;
  endtask

  int hold_seen = 0;
  int hold_left = 0;

  // long hold-off, counted down on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    nms_verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("result with nothing expected, count", out_point_count, 0);
        end else begin
          want = verdict_q.pop_front();
          if (out_valid_res !== want.valid_res)
            note_mismatch("valid_res", out_valid_res, want.valid_res);
          if (out_kept !== want.kept)
            note_mismatch("kept", out_kept, want.kept);
          if (out_x !== want.x)
            note_mismatch("x", out_x, want.x);
          if (out_y !== want.y)
            note_mismatch("y", out_y, want.y);
          if (out_point_count !== want.count)
            note_mismatch("point_count", out_point_count, want.count);
          if (out_overflow !== want.overflow)
            note_mismatch("overflow", out_overflow, want.overflow);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("keypoint_radius_nms_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [OP_BITS-1:0] op, int x, int y, int s, int q);
    nms_item_t it;
    it.op    = op;
    it.x     = COORD_BITS'(x);
    it.y     = COORD_BITS'(y);
    it.score = SCORE_BITS'(s);
    it.qidx  = QIDX_BITS'(q);
    item_q = {item_q, it};
    if (op == OP_LOAD && gen_count < MAX_POINTS) gen_count++;
    if (op == OP_CLEAR) gen_count = 0;
  endfunction

  // Sender pause: wait until every item is in and every result is out,
  // then let any trailing load or clear finish.
  task automatic drain();
    while (item_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RADIUS) radius_cfg = val[RAD_BITS-1:0];
    else margin_cfg = val;
  endtask

  // One batch: mostly clustered loads and queries, usually into a fresh store,
  // with some far-off noise points, stray clears and unused ops mixed in.
  task automatic queue_batch(int n_items);
    int made, r, bx, by, bs, spread, px, py, lx, ly, s, q;
    bit tight;
    made = 0;
    lx = 0;
    ly = 0;
    bx = 0;
    by = 0;
    bs = 0;
    spread = 8;
    tight = 1'b0;
    if ($urandom_range(9) < 8) begin
      push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      made++;
    end
    while (made < n_items) begin
      if (made % 12 == 0) begin
        // new cluster, sometimes hugging the image edges
        spread = $urandom_range(4, 16);
        case ($urandom_range(3))
          0:       bx = 0;
          1:       bx = 1023 - spread;
          default: bx = $urandom_range(1023 - spread);
        endcase
        case ($urandom_range(3))
          0:       by = 1023 - spread;
          1:       by = 0;
          default: by = $urandom_range(1023 - spread);
        endcase
        tight = 1'($urandom_range(1));
        case ($urandom_range(5))
          0:       bs = 0;
          1:       bs = 65535 - 7;
          default: bs = $urandom_range(65535 - 7);
        endcase
      end
      r = $urandom_range(99);
      if (r < 50 && gen_count < CLUSTER_CAP) begin
        if (gen_count > 0 && $urandom_range(9) == 0) begin
          px = lx;   // stack on the previous point's position
          py = ly;
        end else begin
          px = bx + $urandom_range(spread);
          py = by + $urandom_range(spread);
        end
        s = tight ? bs + $urandom_range(7) : $urandom_range(65535);
        push_item(OP_LOAD, px, py, s, $urandom);
        lx = px;
        ly = py;
        made++;
      end else if (r < 88) begin
        if (gen_count > 0 && $urandom_range(9) < 8) q = $urandom_range(gen_count - 1);
        else if ($urandom_range(1)) q = gen_count + $urandom_range(3);
        else q = $urandom_range(1023);
        push_item(OP_QUERY, $urandom, $urandom, $urandom, q);
        made++;
      end else if (r < 93) begin
        push_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 96) begin
        push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (gen_count < CLUSTER_CAP) begin
        push_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom);
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int rad_set [N_SETTINGS];
  int mar_set [N_SETTINGS];

  initial begin
    int ph, k;
    rad_set = '{1, 10, 0, 15, 4, 7, 10, 2};
    mar_set = '{0, 0, 65535, 65535, 5, 300, 3, 65535};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 74;

    // Directed, reset registers (radius 5, margin 0)
    push_item(OP_QUERY, 0, 0, 0, 0);               // empty store, out of range
    push_item(OP_UNUSED, 1023, 1023, 65535, 1023); // ignored
    push_item(OP_LOAD, 100, 100, 1000, 0);
    push_item(OP_LOAD, 103, 104, 2000, 0);         // exactly on the radius: no effect
    push_item(OP_LOAD, 103, 103, 2000, 0);         // inside, higher: beats point 0
    push_item(OP_LOAD, 100, 100, 5000, 0);         // same spot as point 0
    push_item(OP_LOAD, 0, 0, 0, 0);
    push_item(OP_LOAD, 1, 0, 0, 0);                // tie at zero score
    push_item(OP_LOAD, 1023, 1023, 65535, 0);
    push_item(OP_LOAD, 1020, 1023, 65535, 0);      // tie at full score
    for (k = 0; k < 8; k++) push_item(OP_QUERY, 0, 0, 0, k);
    push_item(OP_QUERY, 0, 0, 0, 8);
    push_item(OP_QUERY, 0, 0, 0, 1023);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_QUERY, 1023, 1023, 65535, 0);

    // Random batches over several register settings
    for (ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 74;
      end else if (ph < PRESSURE_SET) begin
        send_idle_pct = 74;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      write_reg(REG_RADIUS, CFG_DATA_BITS'(rad_set[ph]));
      write_reg(REG_MARGIN, CFG_DATA_BITS'(mar_set[ph]));
      // long receiver hold-off while the sender keeps pushing
      if (ph == PRESSURE_SET) hold_req++;
      queue_batch(BATCH_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      note_mismatch("expectations never met", verdict_q.size(), 0);
    if (mismatches == 0) begin
      $display("keypoint_radius_nms_tb passed");
    end else begin
      $display("keypoint_radius_nms_tb failed");
    end
    $finish;
  end

endmodule
